@@ rtl/core/egbr_pkg.sv @@
package egbr_pkg;

  // Command codes carried in the cmd field of an input transaction.
  localparam logic [2:0] CMD_PUSH    = 3'd0;
  localparam logic [2:0] CMD_FIXED   = 3'd1;
  localparam logic [2:0] CMD_UE      = 3'd2;
  localparam logic [2:0] CMD_SE      = 3'd3;
  localparam logic [2:0] CMD_RESTART = 3'd4;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_SHORT   = 2'd1;
  localparam logic [1:0] STAT_TOOLONG = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  localparam logic [5:0] MAX_LEAD      = 6'd32;
  localparam logic [2:0] BYTE_LAST_BIT = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_BIT,
    ST_DONE
  } state_t;

  typedef enum logic {
    PH_ZERO,
    PH_SUFFIX
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FIXED,
    KIND_UE,
    KIND_SE
  } kind_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic [5:0] bit_count;
  } in_item_t;

  typedef struct packed {
    logic signed [32:0] value;
    logic [1:0]         status;
    logic [5:0]         bits_used;
  } out_item_t;

  typedef struct packed {
    logic       go;
    kind_t      kind;
    logic [5:0] count;
    logic       push;
    logic       restart;
  } seq_req_t;

  typedef struct packed {
    logic      done;
    out_item_t item;
  } seq_rsp_t;

endpackage

@@ rtl/core/egbr_ram.sv @@
module egbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/egbr_seq.sv @@
module egbr_seq #(
  parameter int BUFFER_BYTES = 16,
  localparam int IDX_W = $clog2(BUFFER_BYTES),
  localparam int CNT_W = $clog2(BUFFER_BYTES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  egbr_pkg::seq_req_t  req,
  input  logic [7:0]          rd_data,
  output logic [IDX_W-1:0]    rd_addr,
  output logic [IDX_W-1:0]    wr_addr,
  output logic                full,
  output logic                busy,
  output egbr_pkg::seq_rsp_t  rsp
);

  import egbr_pkg::*;

  localparam int AV_W = CNT_W + 3;

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  kind_t             kind_r, kind_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [2:0]        boff_r, boff_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [IDX_W-1:0]  cur_slot_r, cur_slot_nxt;
  logic [2:0]        cur_bit_r, cur_bit_nxt;
  logic [3:0]        adv_r, adv_nxt;
  logic [5:0]        taken_r, taken_nxt;
  logic [5:0]        remain_r, remain_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic [1:0]        status_r, status_nxt;

  logic [AV_W-1:0]   avail;
  logic              short_bits;
  logic              bit_in;
  logic              finish;
  logic [5:0]        n_sat;
  logic [CNT_W:0]    wr_sum;
  logic [IDX_W-1:0]  slot_inc;
  logic [32:0]       half;
  logic signed [32:0] value;

  assign avail      = {fill_r, 3'b000} - AV_W'(boff_r);
  assign short_bits = AV_W'(taken_r) >= avail;
  assign bit_in     = rd_data[BYTE_LAST_BIT - cur_bit_r];
  assign n_sat      = (req.count > MAX_LEAD) ? MAX_LEAD : req.count;
  assign slot_inc   = (cur_slot_r == IDX_W'(BUFFER_BYTES - 1)) ? '0 : cur_slot_r + 1'b1;
  assign full       = fill_r >= CNT_W'(BUFFER_BYTES);
  assign rd_addr    = cur_slot_r;

  // Head < depth and fill <= depth, so one conditional subtract wraps the sum.
  assign wr_sum  = (CNT_W + 1)'(head_r) + (CNT_W + 1)'(fill_r);
  assign wr_addr = (wr_sum >= (CNT_W + 1)'(BUFFER_BYTES))
                 ? IDX_W'(wr_sum - (CNT_W + 1)'(BUFFER_BYTES))
                 : wr_sum[IDX_W-1:0];

  always_comb begin
    finish = 1'b0;
    if (phase_r == PH_ZERO) begin
      finish = (taken_r == MAX_LEAD) || (bit_in && (taken_r == 6'd0));
    end else begin
      finish = (remain_r == 6'd1);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (req.go) begin
          state_nxt = ((req.kind == KIND_FIXED) && (n_sat == 6'd0)) ? ST_DONE : ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_BIT;
      end
      ST_BIT: begin
        if (short_bits || finish) begin
          state_nxt = ST_DONE;
        end else if (cur_bit_r == BYTE_LAST_BIT) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and buffer pointers.
  always_comb begin
    phase_nxt    = phase_r;
    kind_nxt     = kind_r;
    head_nxt     = head_r;
    boff_nxt     = boff_r;
    fill_nxt     = fill_r;
    cur_slot_nxt = cur_slot_r;
    cur_bit_nxt  = cur_bit_r;
    adv_nxt      = adv_r;
    taken_nxt    = taken_r;
    remain_nxt   = remain_r;
    acc_nxt      = acc_r;
    status_nxt   = status_r;
    unique case (state_r)
      ST_IDLE: begin
        if (req.restart) begin
          head_nxt = '0;
          boff_nxt = '0;
          fill_nxt = '0;
        end else if (req.push && !full) begin
          fill_nxt = fill_r + 1'b1;
        end
        if (req.go) begin
          kind_nxt     = req.kind;
          phase_nxt    = (req.kind == KIND_FIXED) ? PH_SUFFIX : PH_ZERO;
          remain_nxt   = n_sat;
          acc_nxt      = '0;
          taken_nxt    = '0;
          status_nxt   = STAT_OK;
          cur_slot_nxt = head_r;
          cur_bit_nxt  = boff_r;
          adv_nxt      = '0;
        end
      end
      ST_LOAD: begin
      end
      ST_BIT: begin
        if (short_bits) begin
          status_nxt = STAT_SHORT;
        end else begin
          taken_nxt = taken_r + 1'b1;
          if (cur_bit_r == BYTE_LAST_BIT) begin
            cur_bit_nxt  = '0;
            cur_slot_nxt = slot_inc;
            adv_nxt      = adv_r + 1'b1;
          end else begin
            cur_bit_nxt = cur_bit_r + 1'b1;
          end
          if (phase_r == PH_ZERO) begin
            // After 32 zeros the next bit is taken whatever it is.
            if (taken_r == MAX_LEAD) begin
              status_nxt = STAT_TOOLONG;
            end else if (bit_in) begin
              acc_nxt    = 32'd1;
              remain_nxt = taken_r;
              phase_nxt  = PH_SUFFIX;
            end
          end else begin
            acc_nxt    = {acc_r[30:0], bit_in};
            remain_nxt = remain_r - 1'b1;
          end
        end
      end
      ST_DONE: begin
        if ((status_r == STAT_OK) || (status_r == STAT_TOOLONG)) begin
          head_nxt = cur_slot_r;
          boff_nxt = cur_bit_r;
          fill_nxt = fill_r - CNT_W'(adv_r);
        end
      end
    endcase
  end

  // The accumulator holds the code value plus one for Exp-Golomb reads.
  assign half = {2'b00, acc_r[31:1]};

  always_comb begin
    value = '0;
    unique case (kind_r)
      KIND_FIXED: value = $signed({1'b0, acc_r});
      KIND_UE:    value = $signed({1'b0, acc_r}) - 33'sd1;
      KIND_SE:    value = acc_r[0] ? -$signed(half) : $signed(half);
      default:    value = '0;
    endcase
  end

  // Outputs.
  always_comb begin
    busy = (state_r != ST_IDLE);
    rsp  = '0;
    if (state_r == ST_DONE) begin
      rsp.done        = 1'b1;
      rsp.item.status = status_r;
      if (status_r == STAT_OK) begin
        rsp.item.value     = value;
        rsp.item.bits_used = taken_r;
      end else if (status_r == STAT_TOOLONG) begin
        rsp.item.bits_used = taken_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      boff_r  <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      boff_r  <= boff_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r    <= phase_nxt;
    kind_r     <= kind_nxt;
    cur_slot_r <= cur_slot_nxt;
    cur_bit_r  <= cur_bit_nxt;
    adv_r      <= adv_nxt;
    taken_r    <= taken_nxt;
    remain_r   <= remain_nxt;
    acc_r      <= acc_nxt;
    status_r   <= status_nxt;
  end

endmodule

@@ rtl/core/exp_golomb_bit_reader.sv @@
// Push, restart and unused commands leave the block idle; a push into a full
// buffer shows its result in the cycle after the transaction. A read takes one
// bit per cycle through the shared shifter, with one RAM read per byte in a load
// state that holds the bit flow, until the field ends or the buffer runs short;
// a done state follows, the result is registered and busy drops in the cycle
// that shows the result. Reset clears the state, buffer pointers and out_valid.
module exp_golomb_bit_reader #(
  parameter int BUFFER_BYTES = 16,
  localparam int IDX_W = $clog2(BUFFER_BYTES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  egbr_pkg::in_item_t  in_item,
  output logic                out_valid,
  output egbr_pkg::out_item_t out_result
);

  import egbr_pkg::*;

  logic             accept;
  seq_req_t         req;
  seq_rsp_t         rsp;
  logic [7:0]       rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             full;
  logic             seq_busy;
  logic             push_drop;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_result_r, out_result_nxt;

  assign accept = start && !busy;
  assign busy   = seq_busy;

  always_comb begin
    req       = '0;
    req.count = in_item.bit_count;
    req.kind  = KIND_FIXED;
    if (accept) begin
      unique case (in_item.cmd)
        CMD_PUSH:    req.push = 1'b1;
        CMD_FIXED: begin
          req.go   = 1'b1;
          req.kind = KIND_FIXED;
        end
        CMD_UE: begin
          req.go   = 1'b1;
          req.kind = KIND_UE;
        end
        CMD_SE: begin
          req.go   = 1'b1;
          req.kind = KIND_SE;
        end
        CMD_RESTART: req.restart = 1'b1;
        default: ;
      endcase
    end
  end

  assign push_drop = req.push && full;

  egbr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.push && !full),
    .wr_addr (wr_addr),
    .wr_data (in_item.data_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  egbr_seq #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .full    (full),
    .busy    (seq_busy),
    .rsp     (rsp)
  );

  always_comb begin
    out_valid_nxt  = rsp.done || push_drop;
    out_result_nxt = rsp.item;
    if (push_drop) begin
      out_result_nxt        = '0;
      out_result_nxt.status = STAT_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

@@ verif/tb_exp_golomb_bit_reader.sv @@
`timescale 1ns / 100ps

module tb_exp_golomb_bit_reader;
  import egbr_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 100;

  // Tracks the byte buffer and read position, and holds the results still owed.
  class reader_scoreboard;
    logic [7:0]  store [DEPTH];
    int          head;
    int          bit_off;
    int          fill;
    out_item_t   owed_results[$];
    int          mismatch_count;

    function new();
      head = 0;
      bit_off = 0;
      fill = 0;
      mismatch_count = 0;
    endfunction

    function int avail();
      return fill * 8 - bit_off;
    endfunction

    function bit stream_bit(int p);
      int pos;
      pos = bit_off + p;
      return store[(head + pos / 8) % DEPTH][7 - pos % 8];
    endfunction

    function bit [63:0] stream_bits(int first, int n);
      bit [63:0] v;
      v = '0;
      for (int i = 0; i < n; i++) v = (v << 1) | stream_bit(first + i);
      return v;
    endfunction

    function void consume(int n);
      int pos;
      pos = bit_off + n;
      head = (head + pos / 8) % DEPTH;
      fill = fill - pos / 8;
      bit_off = pos % 8;
    endfunction

    // Exp-Golomb code number; nothing moves unless the whole code is buffered.
    function bit [1:0] decode_code(output bit [63:0] code, output int used);
      int have;
      int lead;
      have = avail();
      lead = 0;
      code = '0;
      used = 0;
      while (lead < int'(MAX_LEAD)) begin
        if (lead >= have) return STAT_SHORT;
        if (stream_bit(lead)) break;
        lead++;
      end
      if (lead == int'(MAX_LEAD)) begin
        if (have < int'(MAX_LEAD) + 1) return STAT_SHORT;
        used = int'(MAX_LEAD) + 1;
        consume(used);
        return STAT_TOOLONG;
      end
      if (have < 2 * lead + 1) return STAT_SHORT;
      code = ((64'd1 << lead) - 64'd1) + stream_bits(lead + 1, lead);
      used = 2 * lead + 1;
      consume(used);
      return STAT_OK;
    endfunction

    function void note_command(in_item_t it);
      out_item_t res;
      bit [63:0] v;
      bit [63:0] k;
      bit [1:0]  st;
      int        used;
      int        n;
      bit        emit;
      v = '0;
      used = 0;
      st = STAT_OK;
      emit = 1'b1;
      case (it.cmd)
        CMD_PUSH: begin
          if (fill >= DEPTH) begin
            st = STAT_FULL;
          end else begin
            store[(head + fill) % DEPTH] = it.data_byte;
            fill++;
            emit = 1'b0;
          end
        end
        CMD_FIXED: begin
          n = (it.bit_count > 6'd32) ? 32 : int'(it.bit_count);
          if (avail() < n) begin
            st = STAT_SHORT;
          end else begin
            v = stream_bits(0, n);
            used = n;
            consume(n);
          end
        end
        CMD_UE: st = decode_code(v, used);
        CMD_SE: begin
          st = decode_code(k, used);
          if (st == STAT_OK) v = k[0] ? (k + 64'd1) >> 1 : -(k >> 1);
        end
        CMD_RESTART: begin
          head = 0;
          bit_off = 0;
          fill = 0;
          emit = 1'b0;
        end
        default: emit = 1'b0;
      endcase
      if (emit) begin
        res.value = v[32:0];
        res.status = st;
        res.bits_used = used[5:0];
        owed_results.push_back(res);
      end
    endfunction

    function void check_read_result(out_item_t got);
      out_item_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: result with none owed: value %0d status %0d bits_used %0d",
                 $time, got.value, got.status, got.bits_used);
        mismatch_count++;
        return;
      end
      want = owed_results.pop_front();
      if (got.value !== want.value) begin
        $display("%0t: value expected %0d got %0d", $time, want.value, got.value);
        mismatch_count++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        mismatch_count++;
      end
      if (got.bits_used !== want.bits_used) begin
        $display("%0t: bits_used expected %0d got %0d", $time, want.bits_used,
                 got.bits_used);
        mismatch_count++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_result;

  reader_scoreboard bit_stream = new();
  int gap_pct = 0;
  int commands_sent = 0;
  int cycle_count = 0;

  exp_golomb_bit_reader #(.BUFFER_BYTES(DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) bit_stream.check_read_result(out_result);
      if (start && !busy) bit_stream.note_command(in_item);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Holds the command until the block takes it; the sender may idle first.
  task automatic issue_command(in_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    commands_sent++;
  endtask

  task automatic push_byte(logic [7:0] b);
    in_item_t it;
    it.cmd = CMD_PUSH;
    it.data_byte = b;
    it.bit_count = 6'($urandom);
    issue_command(it);
  endtask

  task automatic read_field(logic [2:0] op, logic [5:0] count);
    in_item_t it;
    it.cmd = op;
    it.data_byte = 8'($urandom);
    it.bit_count = count;
    issue_command(it);
  endtask

  // Plenty of zero and near-zero bytes so that long codes turn up.
  function automatic logic [7:0] stream_byte();
    case ($urandom_range(9))
      0, 1:    return 8'h00;
      2:       return 8'($urandom_range(3, 1));
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    in_item_t   it;
    logic [2:0] op;
    int         target;
    int         pick;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: reads on an empty buffer, a code of 32 leading zeros,
    // saturated and zero-length fixed reads, signs of se(v), restart.
    read_field(CMD_FIXED, 6'd5);
    read_field(CMD_UE, 6'd0);
    read_field(CMD_SE, 6'd0);
    repeat (4) push_byte(8'h00);
    push_byte(8'h80);
    read_field(CMD_UE, 6'd0);
    push_byte(8'hFF);
    read_field(CMD_FIXED, 6'd63);
    read_field(CMD_FIXED, 6'd0);
    push_byte(8'h5A);
    push_byte(8'hA5);
    read_field(CMD_SE, 6'd0);
    read_field(CMD_UE, 6'd0);
    read_field(CMD_SE, 6'd0);
    read_field(CMD_FIXED, 6'd12);
    it.cmd = 3'd7;
    it.data_byte = 8'hFF;
    it.bit_count = 6'h3F;
    issue_command(it);
    read_field(CMD_RESTART, 6'd0);
    repeat (4) push_byte(8'hFF);
    read_field(CMD_FIXED, 6'd32);

    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 9 : (ph == 1) ? 45 : 0;
      target = commands_sent + 120;
      while (commands_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          // Long bursts of pushes run into the full buffer.
          repeat ($urandom_range(20, 6)) push_byte(stream_byte());
        end else if (pick < 12) begin
          read_field(CMD_RESTART, 6'($urandom));
        end else if (pick < 15) begin
          it.cmd = 3'($urandom_range(7, 5));
          it.data_byte = 8'($urandom);
          it.bit_count = 6'($urandom);
          issue_command(it);
        end else begin
          repeat ($urandom_range(3)) push_byte(stream_byte());
          repeat ($urandom_range(3, 1)) begin
            case ($urandom_range(2))
              0:       op = CMD_FIXED;
              1:       op = CMD_UE;
              default: op = CMD_SE;
            endcase
            read_field(op, ($urandom_range(9) == 0) ? 6'($urandom_range(63, 33))
                                                     : 6'($urandom_range(32)));
          end
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (bit_stream.owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (bit_stream.mismatch_count == 0 && bit_stream.owed_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
